// ===== design/lpfr_pkg.sv =====
// ---------------------------------------------------------------------------
// lpfr_pkg: shared types and constants for the length-prefixed frame receiver
// Transfer structs, status codes, register indexes and register reset values.
// ---------------------------------------------------------------------------
package lpfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // Request types
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'd0;
  localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd252;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   payload_index;
    logic [BYTE_W-1:0]   payload_len;
  } out_item_t;

endpackage

// ===== design/length_prefixed_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Byte-wide deframer: hunt for header, check version, take a two-byte
// big-endian length, then pass payload bytes out with their index.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transfer per
//   received byte, or a receiver-reset request (req_type set). Every input
//   transfer produces exactly one result transfer on the output channel
//   (out_valid/out_ready/out_data).
//   The result is registered: it sits in the output register in the cycle after
//   the input transfer. Throughput: one byte per cycle while the output is
//   drained; all phase logic is a single level of compare/decrement between
//   the state registers and the output register.
//   Stall: while a result sits unclaimed, in_ready drops; in_ready is high
//   whenever the output register is empty or being drained in the same cycle,
//   so a continuously ready sink sees no bubbles.
//   Config: cfg_wr_en/cfg_index/cfg_data write header, version and max length;
//   writes to unused indexes are dropped. Write only while idle.
//   Reset (rst, synchronous): phase returns to hunt, counters clear, the
//   output register empties, config registers take their defaults.
//   A length above max_payload or a bad version byte reports invalid and
//   returns to hunt; a zero length reports ok at once with an empty payload.
// ---------------------------------------------------------------------------
module length_prefixed_frame_receiver
  import lpfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input byte channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // Receiver phases
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_VERSION = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  // Configuration registers
  logic [BYTE_W-1:0] header_value;
  logic [BYTE_W-1:0] version_value;
  logic [BYTE_W-1:0] max_payload;

  // Receiver state. Lengths above 255 are always rejected (max_payload is
  // 8 bits), so only the high length byte is kept and the remaining count
  // fits in 8 bits.
  logic [1:0]        phase,       phase_next;
  logic [BYTE_W-1:0] len_hi,      len_hi_next;
  logic              len_second,  len_second_next;  // next length byte is low
  logic [BYTE_W-1:0] bytes_left,  bytes_left_next;
  logic [BYTE_W-1:0] recv_count,  recv_count_next;

  out_item_t         result;
  logic              load;

  // Output register frees up when empty or drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // ---- config writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= HEADER_RESET;
      version_value <= VERSION_RESET;
      max_payload   <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEADER:  header_value  <= cfg_data;
        REG_VERSION: version_value <= cfg_data;
        REG_MAX_LEN: max_payload   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- phase logic for one accepted transfer ----
  always_comb begin
    phase_next      = phase;
    len_hi_next     = len_hi;
    len_second_next = len_second;
    bytes_left_next = bytes_left;
    recv_count_next = recv_count;

    result.status        = ST_NONE;
    result.payload_valid = 1'b0;
    result.payload_byte  = '0;
    result.payload_index = '0;

    if (in_data.req_type == REQ_RESET) begin
      phase_next      = PH_HUNT;
      len_hi_next     = '0;
      len_second_next = 1'b0;
      bytes_left_next = '0;
      recv_count_next = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (in_data.rx_byte == header_value) begin
            phase_next = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (in_data.rx_byte == version_value) begin
            phase_next      = PH_LENGTH;
            len_hi_next     = '0;
            len_second_next = 1'b0;
          end else begin
            result.status = ST_INVALID;
            phase_next    = PH_HUNT;
          end
        end
        PH_LENGTH: begin
          if (!len_second) begin
            len_hi_next     = in_data.rx_byte;
            len_second_next = 1'b1;
          end else if ((len_hi != '0) || (in_data.rx_byte > max_payload)) begin
            result.status = ST_INVALID;
            phase_next    = PH_HUNT;
          end else if (in_data.rx_byte == '0) begin
            recv_count_next = '0;
            result.status   = ST_OK;
            phase_next      = PH_HUNT;
          end else begin
            recv_count_next = '0;
            bytes_left_next = in_data.rx_byte;
            phase_next      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = in_data.rx_byte;
          result.payload_index = recv_count;
          recv_count_next      = recv_count + 8'd1;
          bytes_left_next      = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            result.status = ST_OK;
            phase_next    = PH_HUNT;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end

    result.payload_len = recv_count_next;
  end

  // ---- state registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      len_hi     <= '0;
      len_second <= 1'b0;
      bytes_left <= '0;
      recv_count <= '0;
    end else if (load) begin
      phase      <= phase_next;
      len_hi     <= len_hi_next;
      len_second <= len_second_next;
      bytes_left <= bytes_left_next;
      recv_count <= recv_count_next;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  // every accepted byte leaves a result behind
  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("accepted transfer produced no result");

  // payload phase always has bytes outstanding
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with zero bytes left");

  // the closing payload byte reports the full frame length
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.payload_valid && (out_data.status == ST_OK))
      |-> (out_data.payload_len == out_data.payload_index + 8'd1))
    else $error("frame length mismatch on last payload byte");

  // length phase only holds a high byte between the two length bytes
  a_len_hi: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LENGTH && !len_second) |-> (len_hi == '0))
    else $error("stale high length byte");
`endif

endmodule
